// File: rtl/uvsf_pkg.sv
// Shared types, constants and arithmetic helpers for the UV sphere facet generator.
// Used by uvsf_div_cell, uvsf_sine and uv_sphere_facet_generator_top; depends on nothing.
package uvsf_pkg;

    localparam int MAX_RINGS    = 256;
    localparam int MAX_SECTIONS = 256;
    localparam int CNT_W        = 9;
    localparam int RAD_W        = 15;
    localparam int IDX_W        = 8;
    localparam int COORD_W      = 16;
    localparam int PHASE_W      = 16;

    // Divider: 17 quotient bits, one per cell; the divisor enters shifted by 16.
    localparam int DIV_STEPS = 17;
    localparam int REM_W     = 25;

    // Register stages of one sine unit.
    localparam int SINE_LAT = 6;

    localparam logic [CNT_W-1:0] RING_RESET    = CNT_W'(40);
    localparam logic [CNT_W-1:0] SECTION_RESET = CNT_W'(40);
    localparam logic [RAD_W-1:0] RADIUS_RESET  = RAD_W'(16384);
    localparam logic [CNT_W-1:0] RING_CLAMP    = CNT_W'(MAX_RINGS);
    localparam logic [CNT_W-1:0] SECTION_CLAMP = CNT_W'(MAX_SECTIONS);

    // Sine polynomial coefficients in Q16.
    localparam logic [16:0] COEF_A = 17'd102944;
    localparam logic [15:0] COEF_B = 16'd42047;
    localparam logic [12:0] COEF_C = 13'd4639;

    localparam logic [PHASE_W-1:0] QUARTER_TURN = PHASE_W'(16384);

    typedef enum logic [1:0] {
        CFG_RING_COUNT    = 2'd0,
        CFG_SECTION_COUNT = 2'd1,
        CFG_SPHERE_RADIUS = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] column_index;
    } t_cell_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
        logic signed [COORD_W-1:0] third_x;
        logic signed [COORD_W-1:0] third_y;
        logic signed [COORD_W-1:0] third_z;
        logic                      last_facet;
        logic                      index_error;
    } t_result_item;

    typedef struct packed {
        logic [REM_W-1:0]     rem;
        logic [REM_W-1:0]     dsh;
        logic [DIV_STEPS-1:0] quo;
    } t_div_lane;

    // One beat is one ring of the cell: beat 0 the upper ring, beat 1 the lower one.
    typedef struct packed {
        logic valid;
        logic sub;
        logic err;
        logic north;
        logic south;
    } t_beat_tag;

    function automatic t_div_lane div_step(input t_div_lane l);
        t_div_lane r;
        logic      ge;
        ge    = (l.rem >= l.dsh);
        r.rem = ge ? (l.rem - l.dsh) : l.rem;
        r.dsh = l.dsh >> 1;
        r.quo = {l.quo[DIV_STEPS-2:0], ge};
        return r;
    endfunction

    // Q1.15 product rounded half away from zero.
    function automatic logic signed [COORD_W-1:0] q15_mul(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic [15:0] ua;
        logic [15:0] ub;
        logic [31:0] prod;
        logic [15:0] mag;
        logic        neg;
        neg  = a[15] ^ b[15];
        ua   = a[15] ? (~a + 16'd1) : a;
        ub   = b[15] ? (~b + 16'd1) : b;
        prod = {16'd0, ua} * {16'd0, ub};
        prod = prod + 32'd16384;
        mag  = prod[30:15];
        return neg ? signed'(~mag + 16'd1) : signed'(mag);
    endfunction

endpackage

// File: rtl/uvsf_div_cell.sv
// One cell of the divider chain: one restoring quotient bit for the ring lane and
// the section lane. Depends on uvsf_pkg.
module uvsf_div_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  uvsf_pkg::t_div_lane  i_theta,
    input  uvsf_pkg::t_div_lane  i_phi,
    input  uvsf_pkg::t_beat_tag  i_tag,
    output uvsf_pkg::t_div_lane  o_theta,
    output uvsf_pkg::t_div_lane  o_phi,
    output uvsf_pkg::t_beat_tag  o_tag
);

    uvsf_pkg::t_div_lane r_theta;
    uvsf_pkg::t_div_lane r_phi;
    uvsf_pkg::t_beat_tag r_tag;

    always_ff @(posedge i_clk) begin
        r_theta <= uvsf_pkg::div_step(i_theta);
        r_phi   <= uvsf_pkg::div_step(i_phi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    assign o_theta = r_theta;
    assign o_phi   = r_phi;
    assign o_tag   = r_tag;

endmodule

// File: rtl/uvsf_sine.sv
// Pipelined Q1.15 sine of a 16-bit phase, six register stages, at most one multiply per stage.
// Depends on uvsf_pkg for the polynomial coefficients.
module uvsf_sine (
    input  logic               i_clk,
    input  logic [15:0]        i_phase,
    output logic signed [15:0] o_value
);

    logic [14:0]        r_x0, r_x1, r_x2s, r_x3;
    logic               r_neg0, r_neg1, r_neg2, r_neg3, r_neg4;
    logic [14:0]        r_sq1, r_sq2;
    logic [12:0]        r_t1;
    logic [15:0]        r_t2;
    logic [14:0]        r_mag;
    logic signed [15:0] r_out;

    logic [14:0] x_fold;
    logic [29:0] p1;
    logic [27:0] p2;
    logic [15:0] bm;
    logic [31:0] p3;
    logic [16:0] am;
    logic [32:0] p4;
    logic [17:0] shifted;

    always_comb begin
        // Fold the phase into the first quadrant; odd quadrants run backward.
        x_fold  = i_phase[14] ? (15'd16384 - {1'b0, i_phase[13:0]}) : {1'b0, i_phase[13:0]};
        p1      = {15'd0, r_x0} * {15'd0, r_x0};
        p2      = {15'd0, uvsf_pkg::COEF_C} * {13'd0, r_sq1};
        bm      = uvsf_pkg::COEF_B - {3'd0, r_t1};
        p3      = {16'd0, bm} * {17'd0, r_sq2};
        am      = uvsf_pkg::COEF_A - {1'b0, r_t2};
        p4      = ({16'd0, am} * {18'd0, r_x3}) + 33'd16384;
        shifted = p4[32:15];
    end

    always_ff @(posedge i_clk) begin
        r_x0   <= x_fold;
        r_neg0 <= i_phase[15];

        r_sq1  <= p1[28:14];
        r_x1   <= r_x0;
        r_neg1 <= r_neg0;

        r_t1   <= p2[26:14];
        r_sq2  <= r_sq1;
        r_x2s  <= r_x1;
        r_neg2 <= r_neg1;

        r_t2   <= p3[29:14];
        r_x3   <= r_x2s;
        r_neg3 <= r_neg2;

        r_mag  <= (shifted > 18'd32767) ? 15'd32767 : shifted[14:0];
        r_neg4 <= r_neg3;

        r_out  <= r_neg4 ? signed'(16'd0 - {1'b0, r_mag}) : signed'({1'b0, r_mag});
    end

    assign o_value = r_out;

endmodule

// File: rtl/uv_sphere_facet_generator_top.sv
// Top level of the UV sphere facet generator: entry, divider cell chain, sine units,
// ring and vertex multiply stages, triangle output. Depends on uvsf_pkg, uvsf_div_cell
// and uvsf_sine.
//
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------------
//  cell in   | start, busy        | i_cell (row_index, column_index)
//  facet out | o_strobe           | o_result (three vertices, flags)
//  config    | i_cfg_we           | i_cfg_index, i_cfg_data
//
// Cells overlap in the pipeline; a new cell is refused (busy) only while the lower-ring
// beat of the previous one enters: each cell runs two beats (upper ring and lower ring)
// down a 17-cell divider chain that yields the ring and section phases, one quotient bit
// per cell. Its two triangles leave on consecutive cycles. Reset is synchronous and
// restores the register defaults. The receiver cannot stall, so nothing inside ever waits.
module uv_sphere_facet_generator_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  uvsf_pkg::t_cell_item   i_cell,
    output logic                   o_strobe,
    output uvsf_pkg::t_result_item o_result,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [14:0]            i_cfg_data
);

    logic [8:0]  r_ring_count, r_section_count;
    logic [14:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_count    <= uvsf_pkg::RING_RESET;
            r_section_count <= uvsf_pkg::SECTION_RESET;
            r_radius        <= uvsf_pkg::RADIUS_RESET;
        end else if (i_cfg_we) begin
            case (uvsf_pkg::t_cfg_reg'(i_cfg_index))
                uvsf_pkg::CFG_RING_COUNT:    r_ring_count    <= i_cfg_data[8:0];
                uvsf_pkg::CFG_SECTION_COUNT: r_section_count <= i_cfg_data[8:0];
                uvsf_pkg::CFG_SPHERE_RADIUS: r_radius        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- entry ----------------
    logic [8:0] rings, secs, ring_div;
    logic       accept, second_beat, err_now;
    logic [7:0] ring_idx;
    logic [8:0] col_idx;
    logic [7:0] r_row, r_col;
    logic       r_err;

    uvsf_pkg::t_div_lane w_theta [0:uvsf_pkg::DIV_STEPS];
    uvsf_pkg::t_div_lane w_phi   [0:uvsf_pkg::DIV_STEPS];
    uvsf_pkg::t_beat_tag w_tag   [0:uvsf_pkg::DIV_STEPS];

    uvsf_pkg::t_div_lane r_ent_theta, r_ent_phi, n_ent_theta, n_ent_phi;
    uvsf_pkg::t_beat_tag r_ent_tag, n_ent_tag;

    assign busy = r_ent_tag.valid && !r_ent_tag.sub;

    always_comb begin
        rings       = (r_ring_count > uvsf_pkg::RING_CLAMP) ? uvsf_pkg::RING_CLAMP
                                                             : r_ring_count;
        secs        = (r_section_count > uvsf_pkg::SECTION_CLAMP) ? uvsf_pkg::SECTION_CLAMP
                                                                   : r_section_count;
        ring_div    = rings - 9'd1;
        accept      = start && !busy;
        second_beat = r_ent_tag.valid && !r_ent_tag.sub;
        ring_idx    = accept ? i_cell.row_index : (r_row + 8'd1);
        col_idx     = accept ? {1'b0, i_cell.column_index} : ({1'b0, r_col} + 9'd1);
        err_now     = accept ? (({2'd0, i_cell.row_index} + 10'd2 > {1'b0, rings}) ||
                                ({1'b0, i_cell.column_index} >= secs))
                             : r_err;

        n_ent_tag.valid = accept || second_beat;
        n_ent_tag.sub   = !accept;
        n_ent_tag.err   = err_now;
        n_ent_tag.north = (ring_idx == 8'd0);
        n_ent_tag.south = ({2'd0, ring_idx} + 10'd1 >= {1'b0, rings});

        // Rounding offset is half the divisor; it never reaches the index bits.
        n_ent_theta.rem = {2'd0, ring_idx, 7'd0, ring_div[8:1]};
        n_ent_theta.dsh = {ring_div, 16'd0};
        n_ent_theta.quo = '0;
        n_ent_phi.rem   = {col_idx, 8'd0, secs[8:1]};
        n_ent_phi.dsh   = {secs, 16'd0};
        n_ent_phi.quo   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_tag <= '0;
        end else begin
            r_ent_tag <= n_ent_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent_theta <= n_ent_theta;
        r_ent_phi   <= n_ent_phi;
        if (accept) begin
            r_row <= i_cell.row_index;
            r_col <= i_cell.column_index;
            r_err <= err_now;
        end
    end

    // ---------------- divider chain ----------------
    assign w_theta[0] = r_ent_theta;
    assign w_phi[0]   = r_ent_phi;
    assign w_tag[0]   = r_ent_tag;

    for (genvar g = 0; g < uvsf_pkg::DIV_STEPS; g++) begin : g_div
        uvsf_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_theta (w_theta[g]),
            .i_phi   (w_phi[g]),
            .i_tag   (w_tag[g]),
            .o_theta (w_theta[g+1]),
            .o_phi   (w_phi[g+1]),
            .o_tag   (w_tag[g+1])
        );
    end

    // ---------------- sine and cosine ----------------
    logic [15:0]        theta_ph, phi_ph, theta_cph, phi_cph;
    logic signed [15:0] sin_t, cos_t, sin_p, cos_p;

    assign theta_ph  = w_theta[uvsf_pkg::DIV_STEPS].quo[15:0];
    assign phi_ph    = w_phi[uvsf_pkg::DIV_STEPS].quo[15:0];
    assign theta_cph = theta_ph + uvsf_pkg::QUARTER_TURN;
    assign phi_cph   = phi_ph + uvsf_pkg::QUARTER_TURN;

    uvsf_sine u_sin_t (.i_clk(i_clk), .i_phase(theta_ph),  .o_value(sin_t));
    uvsf_sine u_cos_t (.i_clk(i_clk), .i_phase(theta_cph), .o_value(cos_t));
    uvsf_sine u_sin_p (.i_clk(i_clk), .i_phase(phi_ph),    .o_value(sin_p));
    uvsf_sine u_cos_p (.i_clk(i_clk), .i_phase(phi_cph),   .o_value(cos_p));

    uvsf_pkg::t_beat_tag r_tagd [0:uvsf_pkg::SINE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < uvsf_pkg::SINE_LAT; i++) begin
                r_tagd[i] <= '0;
            end
        end else begin
            r_tagd[0] <= w_tag[uvsf_pkg::DIV_STEPS];
            for (int i = 1; i < uvsf_pkg::SINE_LAT; i++) begin
                r_tagd[i] <= r_tagd[i-1];
            end
        end
    end

    // ---------------- ring point ----------------
    logic signed [15:0] rad_s;
    logic signed [15:0] r_rr, r_z, r_cp, r_sp;
    uvsf_pkg::t_beat_tag r_rtag;
    uvsf_pkg::t_beat_tag tag_t;

    assign rad_s = signed'({1'b0, r_radius});
    assign tag_t = r_tagd[uvsf_pkg::SINE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rtag <= '0;
        end else begin
            r_rtag <= tag_t;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp <= cos_p;
        r_sp <= sin_p;
        if (tag_t.north) begin
            r_rr <= '0;
            r_z  <= rad_s;
        end else if (tag_t.south) begin
            r_rr <= '0;
            r_z  <= -rad_s;
        end else begin
            r_rr <= uvsf_pkg::q15_mul(rad_s, sin_t);
            r_z  <= uvsf_pkg::q15_mul(rad_s, cos_t);
        end
    end

    // Upper-ring beat is held until the lower-ring beat arrives.
    logic signed [15:0] r_h_rr, r_h_z, r_h_cp, r_h_sp;

    always_ff @(posedge i_clk) begin
        if (r_rtag.valid && !r_rtag.sub) begin
            r_h_rr <= r_rr;
            r_h_z  <= r_z;
            r_h_cp <= r_cp;
            r_h_sp <= r_sp;
        end
    end

    // ---------------- vertices ----------------
    logic               r_vx_valid;
    logic               r_v_err;
    logic signed [15:0] r_tp0x, r_tp0y, r_bp0x, r_bp0y, r_bp1x, r_bp1y, r_tp1x, r_tp1y;
    logic signed [15:0] r_zt, r_zb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx_valid <= 1'b0;
        end else begin
            r_vx_valid <= r_rtag.valid && r_rtag.sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rtag.valid && r_rtag.sub) begin
            r_tp0x  <= uvsf_pkg::q15_mul(r_h_rr, r_h_cp);
            r_tp0y  <= uvsf_pkg::q15_mul(r_h_rr, r_h_sp);
            r_bp0x  <= uvsf_pkg::q15_mul(r_rr, r_h_cp);
            r_bp0y  <= uvsf_pkg::q15_mul(r_rr, r_h_sp);
            r_bp1x  <= uvsf_pkg::q15_mul(r_rr, r_cp);
            r_bp1y  <= uvsf_pkg::q15_mul(r_rr, r_sp);
            r_tp1x  <= uvsf_pkg::q15_mul(r_h_rr, r_cp);
            r_tp1y  <= uvsf_pkg::q15_mul(r_h_rr, r_sp);
            r_zt    <= r_h_z;
            r_zb    <= r_z;
            r_v_err <= r_rtag.err;
        end
    end

    // ---------------- triangle output ----------------
    uvsf_pkg::t_result_item tri_a, tri_b, r_out;
    logic r_strobe, r_pend;

    always_comb begin
        tri_a.first_x     = r_tp0x;
        tri_a.first_y     = r_tp0y;
        tri_a.first_z     = r_zt;
        tri_a.second_x    = r_bp0x;
        tri_a.second_y    = r_bp0y;
        tri_a.second_z    = r_zb;
        tri_a.third_x     = r_bp1x;
        tri_a.third_y     = r_bp1y;
        tri_a.third_z     = r_zb;
        tri_a.last_facet  = 1'b0;
        tri_a.index_error = 1'b0;

        tri_b.first_x     = r_tp0x;
        tri_b.first_y     = r_tp0y;
        tri_b.first_z     = r_zt;
        tri_b.second_x    = r_bp1x;
        tri_b.second_y    = r_bp1y;
        tri_b.second_z    = r_zb;
        tri_b.third_x     = r_tp1x;
        tri_b.third_y     = r_tp1y;
        tri_b.third_z     = r_zt;
        tri_b.last_facet  = 1'b1;
        tri_b.index_error = 1'b0;

        // A bad cell index still yields both beats, with all coordinates zero.
        if (r_v_err) begin
            tri_a             = '0;
            tri_a.index_error = 1'b1;
            tri_b             = '0;
            tri_b.last_facet  = 1'b1;
            tri_b.index_error = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_strobe <= r_vx_valid || r_pend;
            r_pend   <= r_vx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vx_valid) begin
            r_out <= tri_a;
        end else if (r_pend) begin
            r_out <= tri_b;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

// File: tb/tb_uv_sphere_facet_generator_top.sv
// Self-checking testbench for uv_sphere_facet_generator_top: drives cell indexes and
// register writes, predicts both triangles of each cell and compares every result beat.
// Depends on uvsf_pkg and the generator RTL.
module tb_uv_sphere_facet_generator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 40;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    uvsf_pkg::t_cell_item   i_cell = '0;
    logic                   o_strobe;
    uvsf_pkg::t_result_item o_result;
    logic                   i_cfg_we = 1'b0;
    logic [1:0]             i_cfg_index = '0;
    logic [14:0]            i_cfg_data = '0;

    int unsigned            rings_reg, sections_reg, radius_reg;
    uvsf_pkg::t_result_item pending_facets[$];
    int                     error_count = 0;

    uv_sphere_facet_generator_top DUT (.*);

    always #2 i_clk = ~i_clk;

    // Sine of a 16-bit phase in Q1.15, folded to one quadrant.
    function automatic int phase_sine(input int unsigned phase);
        int unsigned quad, x;
        longint unsigned x2, t, r;
        quad = (phase >> 14) & 3;
        x = phase & 16'h3FFF;
        if (quad & 1) x = 16384 - x;
        x2 = (longint'(x) * x) >> 14;
        t = (longint'(uvsf_pkg::COEF_C) * x2) >> 14;
        t = longint'(uvsf_pkg::COEF_B) - t;
        t = (t * x2) >> 14;
        t = longint'(uvsf_pkg::COEF_A) - t;
        r = (t * x + 16384) >> 15;
        if (r > 32767) r = 32767;
        return (quad >= 2) ? -int'(r) : int'(r);
    endfunction

    function automatic int phase_cosine(input int unsigned phase);
        return phase_sine((phase + 16384) & 16'hFFFF);
    endfunction

    function automatic int scale_q15(input int a, input int b);
        longint unsigned ua, ub, m;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        m = (ua * ub + 16384) >> 15;
        return ((a < 0) != (b < 0)) ? -int'(m) : int'(m);
    endfunction

    task automatic ring_geometry(input int unsigned ring, input int unsigned rings,
                                 output int rr, output int z);
        int unsigned d, phase;
        if (ring == 0) begin
            rr = 0;
            z = int'(radius_reg);
        end else if (ring >= rings - 1) begin
            rr = 0;
            z = -int'(radius_reg);
        end else begin
            d = rings - 1;
            phase = ((ring * 32768 + d / 2) / d) & 16'hFFFF;
            rr = scale_q15(radius_reg, phase_sine(phase));
            z = scale_q15(radius_reg, phase_cosine(phase));
        end
    endtask

    task automatic predict_facets(input uvsf_pkg::t_cell_item cell_in);
        int unsigned rings, secs, p0, p1;
        int rt, zt, rb, zb;
        uvsf_pkg::t_result_item f1, f2;
        rings = (rings_reg > uvsf_pkg::MAX_RINGS) ? uvsf_pkg::MAX_RINGS : rings_reg;
        secs = (sections_reg > uvsf_pkg::MAX_SECTIONS) ? uvsf_pkg::MAX_SECTIONS
                                                       : sections_reg;
        f1 = '0;
        f2 = '0;
        f2.last_facet = 1'b1;
        if (cell_in.row_index + 2 > rings || cell_in.column_index >= secs) begin
            f1.index_error = 1'b1;
            f2.index_error = 1'b1;
        end else begin
            ring_geometry(cell_in.row_index, rings, rt, zt);
            ring_geometry(cell_in.row_index + 1, rings, rb, zb);
            p0 = ((cell_in.column_index * 65536 + secs / 2) / secs) & 16'hFFFF;
            p1 = (((cell_in.column_index + 1) * 65536 + secs / 2) / secs) & 16'hFFFF;
            f1.first_x  = 16'(scale_q15(rt, phase_cosine(p0)));
            f1.first_y  = 16'(scale_q15(rt, phase_sine(p0)));
            f1.first_z  = 16'(zt);
            f1.second_x = 16'(scale_q15(rb, phase_cosine(p0)));
            f1.second_y = 16'(scale_q15(rb, phase_sine(p0)));
            f1.second_z = 16'(zb);
            f1.third_x  = 16'(scale_q15(rb, phase_cosine(p1)));
            f1.third_y  = 16'(scale_q15(rb, phase_sine(p1)));
            f1.third_z  = 16'(zb);
            f2.first_x  = f1.first_x;
            f2.first_y  = f1.first_y;
            f2.first_z  = 16'(zt);
            f2.second_x = f1.third_x;
            f2.second_y = f1.third_y;
            f2.second_z = 16'(zb);
            f2.third_x  = 16'(scale_q15(rt, phase_cosine(p1)));
            f2.third_y  = 16'(scale_q15(rt, phase_sine(p1)));
            f2.third_z  = 16'(zt);
        end
        pending_facets.push_back(f1);
        pending_facets.push_back(f2);
    endtask

    // Every strobed beat is checked against the oldest predicted facet.
    always @(posedge i_clk) begin
        uvsf_pkg::t_result_item want;
        if (i_rst_n && o_strobe) begin
            if (pending_facets.size() == 0) begin
                $display("%0t: unexpected facet %h", $time, o_result);
                error_count++;
            end else begin
                want = pending_facets.pop_front();
                if (o_result !== want) begin
                    $display("%0t: facet mismatch expected %h actual %h",
                             $time, want, o_result);
                    error_count++;
                end
            end
        end
    end

    // Leaves start high so that the next cell can follow without a gap.
    task automatic send_cell(input logic [7:0] row, input logic [7:0] col);
        uvsf_pkg::t_cell_item cell_in;
        cell_in.row_index = row;
        cell_in.column_index = col;
        i_cell <= cell_in;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        predict_facets(cell_in);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_facets.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input uvsf_pkg::t_cfg_reg idx, input int unsigned value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 15'(value);
        @(posedge i_clk);
        case (idx)
            uvsf_pkg::CFG_RING_COUNT:    rings_reg = value & 9'h1FF;
            uvsf_pkg::CFG_SECTION_COUNT: sections_reg = value & 9'h1FF;
            uvsf_pkg::CFG_SPHERE_RADIUS: radius_reg = value & 15'h7FFF;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_shape(input int unsigned rings, input int unsigned secs,
                             input int unsigned rad);
        wait_idle();
        write_reg(uvsf_pkg::CFG_RING_COUNT, rings);
        write_reg(uvsf_pkg::CFG_SECTION_COUNT, secs);
        write_reg(uvsf_pkg::CFG_SPHERE_RADIUS, rad);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_directed();
        send_cell(0, 0);
        send_cell(38, 39);
        send_cell(39, 0);
        send_cell(0, 40);
        send_cell(8'hFF, 8'hFF);
        send_cell(19, 20);
        set_shape(3, 3, 32767);
        send_cell(0, 0);
        send_cell(1, 2);
        send_cell(2, 0);
        send_cell(0, 3);
        set_shape(2, 1, 0);
        send_cell(0, 0);
        send_cell(0, 1);
        set_shape(256, 256, 1);
        send_cell(254, 255);
        send_cell(0, 255);
        send_cell(127, 128);
        set_shape(511, 2, 32767);
        send_cell(254, 1);
        send_cell(8'hAA, 0);
        send_cell(8'h55, 1);
    endtask

    // Mostly in-range cells, with a share of out-of-range indexes.
    task automatic test_random(input int unsigned count);
        int unsigned rings, secs, gap;
        logic [7:0] row, col;
        rings = (rings_reg > uvsf_pkg::MAX_RINGS) ? uvsf_pkg::MAX_RINGS : rings_reg;
        secs = (sections_reg > uvsf_pkg::MAX_SECTIONS) ? uvsf_pkg::MAX_SECTIONS
                                                       : sections_reg;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) != 0 && rings >= 2 && secs >= 1) begin
                row = 8'($urandom_range(rings - 2));
                col = 8'($urandom_range(secs - 1));
            end else begin
                row = 8'($urandom);
                col = 8'($urandom);
            end
            send_cell(row, col);
            gap = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0;
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    initial begin
        rings_reg = uvsf_pkg::RING_RESET;
        sections_reg = uvsf_pkg::SECTION_RESET;
        radius_reg = uvsf_pkg::RADIUS_RESET;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        set_shape(40, 40, 16384);
        test_random(300);
        set_shape(256, 256, 32767);
        test_random(300);
        set_shape(3, 3, 0);
        test_random(150);
        set_shape($urandom_range(3, 511), $urandom_range(3, 511), $urandom_range(32767));
        test_random(300);
        set_shape(17, 200, 12345);
        test_random(250);
        set_shape($urandom_range(3, 64), $urandom_range(3, 64), $urandom_range(32767));
        test_random(230);
        wait_idle();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end
endmodule

// File: uv_sphere_facet_generator_top.f
rtl/uvsf_pkg.sv
rtl/uvsf_div_cell.sv
rtl/uvsf_sine.sv
rtl/uv_sphere_facet_generator_top.sv
tb/tb_uv_sphere_facet_generator_top.sv
